### src/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros shared by the RTL files.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// When the trigger holds, the condition must hold in the same cycle.
`define ASSERT_IMPL(label, clk, rst, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
    else $error(msg);

// When the trigger holds, the condition must hold in the next cycle.
`define ASSERT_NEXT(label, clk, rst, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
    else $error(msg);

`endif

### src/mspf_pkg.sv
// ---------------------------------------------------------------------------
// mspf_pkg
// Constants, byte positions and CRC step functions for the set-command
// packet framer.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mspf_pkg;

  // Packet layout.
  localparam int unsigned PKT_LEN   = 10;
  localparam int unsigned POS_W     = 4;

  localparam logic [POS_W-1:0] POS_ADDR   = 4'd0;
  localparam logic [POS_W-1:0] POS_CMD    = 4'd1;
  localparam logic [POS_W-1:0] POS_KIND   = 4'd2;
  localparam logic [POS_W-1:0] POS_CRC7   = 4'd3;
  localparam logic [POS_W-1:0] POS_MAG_LO = 4'd4;
  localparam logic [POS_W-1:0] POS_MAG_HI = 4'd5;
  localparam logic [POS_W-1:0] POS_TKIND  = 4'd6;
  localparam logic [POS_W-1:0] POS_TIDX   = 4'd7;
  localparam logic [POS_W-1:0] POS_C14_LO = 4'd8;
  localparam logic [POS_W-1:0] POS_C14_HI = 4'd9;

  // Field constants.
  localparam logic [7:0]  ADDR_OFFSET  = 8'd112;
  localparam logic [7:0]  CMD_SET      = 8'd40;
  localparam logic [7:0]  ADDR_RESET   = 8'd16;
  localparam logic [13:0] MAG_MAX      = 14'd16383;

  // CRC-7 (reflected) and CRC-14 (reflected) parameters.
  localparam logic [6:0]  CRC7_INIT    = 7'h7f;
  localparam logic [6:0]  CRC7_POLY    = 7'h76;
  localparam logic [6:0]  CRC7_XOR     = 7'h7f;
  localparam logic [13:0] CRC14_INIT   = 14'h3fff;
  localparam logic [13:0] CRC14_POLY   = 14'h22f0;
  localparam logic [13:0] CRC14_XOR    = 14'h3fff;

  // Register map.
  localparam logic REG_DEVICE_ADDRESS = 1'b0;

  // Fold one byte into a reflected CRC-7, eight shifts.
  function automatic logic [6:0] crc7_byte(input logic [6:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = {1'b0, crc} ^ data;
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ {1'b0, CRC7_POLY};
      end else begin
        c = c >> 1;
      end
    end
    return c[6:0];
  endfunction

  // Fold one byte into a reflected CRC-14, eight shifts.
  function automatic logic [13:0] crc14_byte(input logic [13:0] crc, input logic [7:0] data);
    logic [13:0] c;
    c = crc ^ {6'd0, data};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC14_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

### src/motor_set_packet_framer.sv
// ---------------------------------------------------------------------------
// motor_set_packet_framer
// Turns one set command into a ten-byte motor-controller packet with a
// CRC-7 protected header and a CRC-14 protected payload.
// ---------------------------------------------------------------------------
// Each accepted request produces ten bytes on the master side, one per cycle
// while the sink is ready, with tlast on the tenth. The first byte is loaded
// into the output register after the accepted request sets the busy flag,
// and a new request is taken in the same cycle as the tenth byte is loaded, so
// packets follow without a gap while the sink is ready; the byte serializer
// folds each header and payload byte into its running CRC as it is loaded. The
// device address register is written over the APB port at byte address 0 and
// must only change while no packet is in flight.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module motor_set_packet_framer (
  input  wire logic        clk,
  input  wire logic        rst,
  // Slave request stream.
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // [7:0] set_kind, [15:8] target_kind, [23:16] target_index,
  // [38:24] signed_value, [39] zero
  input  wire logic [39:0] s_tdata,
  // Master packet stream.
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // [7:0] packet_byte
  output logic [7:0]       m_tdata,
  output logic             m_tlast,
  // APB configuration port.
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  // Configuration register.
  logic [7:0] device_address;

  // Latched command.
  logic [7:0]  kind;
  logic [13:0] mag;
  logic [7:0]  tkind;
  logic [7:0]  tidx;

  // Serializer control.
  logic                      busy;
  logic [mspf_pkg::POS_W-1:0] pos;
  logic [6:0]                crc7;
  logic [13:0]               crc14;

  logic        adv;
  logic        s_accept;
  logic        last_pos;
  logic [7:0]  byte_next;
  logic [13:0] crc14_fin;

  // Request fields.
  logic [7:0]  in_set_kind;
  logic [7:0]  in_target_kind;
  logic [7:0]  in_target_index;
  logic [14:0] in_signed_value;
  logic        in_neg;
  logic [14:0] in_abs;
  logic [13:0] in_mag;

  assign in_set_kind     = s_tdata[7:0];
  assign in_target_kind  = s_tdata[15:8];
  assign in_target_index = s_tdata[23:16];
  assign in_signed_value = s_tdata[38:24];

  // Magnitude with saturation of the most negative value.
  assign in_neg = in_signed_value[14];
  assign in_abs = in_neg ? (15'd0 - in_signed_value) : in_signed_value;
  assign in_mag = in_abs[14] ? mspf_pkg::MAG_MAX : in_abs[13:0];

  // Handshake: the output register moves when empty or taken.
  assign adv      = !m_tvalid || m_tready;
  assign last_pos = (pos == mspf_pkg::POS_C14_HI);
  assign s_tready = !busy || (last_pos && adv);
  assign s_accept = s_tvalid && s_tready;

  // APB access.
  assign pready = 1'b1;
  always_comb begin
    prdata = 32'd0;
    if (paddr[2] == mspf_pkg::REG_DEVICE_ADDRESS) begin
      prdata = {24'd0, device_address};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      device_address <= mspf_pkg::ADDR_RESET;
    end else if (psel && penable && pwrite && pready &&
                 (paddr[2] == mspf_pkg::REG_DEVICE_ADDRESS)) begin
      device_address <= pwdata[7:0];
    end
  end

  // Byte selection for the current packet position.
  assign crc14_fin = crc14 ^ mspf_pkg::CRC14_XOR;
  always_comb begin
    case (pos)
      mspf_pkg::POS_ADDR:   byte_next = device_address + mspf_pkg::ADDR_OFFSET;
      mspf_pkg::POS_CMD:    byte_next = mspf_pkg::CMD_SET;
      mspf_pkg::POS_KIND:   byte_next = kind;
      mspf_pkg::POS_CRC7:   byte_next = {1'b0, crc7 ^ mspf_pkg::CRC7_XOR};
      mspf_pkg::POS_MAG_LO: byte_next = {1'b0, mag[6:0]};
      mspf_pkg::POS_MAG_HI: byte_next = {1'b0, mag[13:7]};
      mspf_pkg::POS_TKIND:  byte_next = tkind;
      mspf_pkg::POS_TIDX:   byte_next = tidx;
      mspf_pkg::POS_C14_LO: byte_next = {1'b0, crc14_fin[6:0]};
      mspf_pkg::POS_C14_HI: byte_next = {1'b0, crc14_fin[13:7]};
      default:              byte_next = 8'd0;
    endcase
  end

  // Command latch; the kind byte is bumped for negative values.
  always_ff @(posedge clk) begin
    if (s_accept) begin
      kind  <= in_set_kind + {7'd0, in_neg};
      mag   <= in_mag;
      tkind <= in_target_kind;
      tidx  <= in_target_index;
    end
  end

  // Serializer position and busy flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pos  <= mspf_pkg::POS_ADDR;
    end else if (s_accept) begin
      busy <= 1'b1;
      pos  <= mspf_pkg::POS_ADDR;
    end else if (busy && adv) begin
      if (last_pos) begin
        busy <= 1'b0;
        pos  <= mspf_pkg::POS_ADDR;
      end else begin
        pos <= pos + 1'b1;
      end
    end
  end

  // Running CRCs, one byte folded in per emitted header or payload byte.
  always_ff @(posedge clk) begin
    if (busy && adv) begin
      case (pos)
        mspf_pkg::POS_ADDR:
          crc7 <= mspf_pkg::crc7_byte(mspf_pkg::CRC7_INIT, byte_next);
        mspf_pkg::POS_CMD, mspf_pkg::POS_KIND:
          crc7 <= mspf_pkg::crc7_byte(crc7, byte_next);
        mspf_pkg::POS_MAG_LO:
          crc14 <= mspf_pkg::crc14_byte(mspf_pkg::CRC14_INIT, byte_next);
        mspf_pkg::POS_MAG_HI, mspf_pkg::POS_TKIND, mspf_pkg::POS_TIDX:
          crc14 <= mspf_pkg::crc14_byte(crc14, byte_next);
        default: begin
        end
      endcase
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= busy;
    end
  end

  always_ff @(posedge clk) begin
    if (busy && adv) begin
      m_tdata <= byte_next;
      m_tlast <= last_pos;
    end
  end

  // Checks.
  `ASSERT_IMPL(a_accept_only_at_end, clk, rst, s_accept && busy, last_pos && adv,
    "request accepted while a packet is still being sent")
  `ASSERT_IMPL(a_pos_idle_zero, clk, rst, !busy, pos == mspf_pkg::POS_ADDR,
    "byte position not cleared while idle")
  `ASSERT_NEXT(a_busy_after_accept, clk, rst, s_accept, busy && pos == mspf_pkg::POS_ADDR,
    "serializer did not start after a request")
  `ASSERT_NEXT(a_last_loaded, clk, rst, busy && adv && last_pos, m_tvalid && m_tlast,
    "final byte not marked last")

endmodule

`default_nettype wire
